@@ hw/rtl/alba_pkg.sv @@
// ----------------------------------------------------------------------------
// alba_pkg - shared definitions for the aligned linear bump allocator
// Operation, status and register index codes, plus the handshake structs
// between the top level and the remainder unit.
// ----------------------------------------------------------------------------
package alba_pkg;

    localparam int DEFAULT_OFFSET_WIDTH = 32;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_RESET = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD       = 2'd1;
    localparam logic [1:0] ST_ALIGN_OVF = 2'd2;
    localparam logic [1:0] ST_NO_SPACE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE     = 1'd1;

    typedef struct packed {
        logic start;
    } rem_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rem_sts_t;

endpackage

@@ hw/rtl/alba_rem_unit.sv @@
// ----------------------------------------------------------------------------
// alba_rem_unit - radix-2 restoring remainder unit
// Computes dividend % divisor, one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module alba_rem_unit
    import alba_pkg::*;
#(
    parameter int OFFSET_WIDTH = DEFAULT_OFFSET_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  rem_ctl_t                ctl,
    input  logic [OFFSET_WIDTH-1:0] dividend,
    input  logic [31:0]             divisor,
    output rem_sts_t                sts,
    output logic [31:0]             remainder
);

    localparam int CW = $clog2(OFFSET_WIDTH);

    logic [OFFSET_WIDTH-1:0] div_reg;
    logic [31:0]             rem_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic [31:0] rem_next;

    // shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        trial    = {rem_reg, div_reg[OFFSET_WIDTH-1]};
        diff     = trial - {1'b0, divisor};
        rem_next = diff[32] ? trial[31:0] : diff[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                div_reg  <= dividend;
                rem_reg  <= '0;
                cnt_reg  <= CW'(OFFSET_WIDTH - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                div_reg <= {div_reg[OFFSET_WIDTH-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/aligned_linear_bump_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// aligned_linear_bump_allocator_unit - linear allocator with any alignment
// Rounds the fill level up to a multiple of an arbitrary alignment, checks
// the region against capacity, returns offset and address, bumps the level.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | op, request_size, alignment
//  out      | out_valid / out_ready | ok, status, offset, address, granted_size
//  cfg      | cfg_we (no wait)      | cfg_index, cfg_data
//
//  Allocate: accept, then S_DIV while the remainder unit iterates once per
//  fill-level bit, then S_ADD, S_CHECK and S_FINISH to result valid.
//  Alignment overflow skips S_CHECK and goes from S_ADD to S_FINISH.
//  Reset requests and bad requests go straight from accept to S_FINISH.
//  One transaction in flight; in_ready is high only in idle.
//  A stalled result holds the block in its final state until taken.
//  rst_n clears fill level, capacity, base address and all control.
//
module aligned_linear_bump_allocator_unit
    import alba_pkg::*;
#(
    parameter int OFFSET_WIDTH = DEFAULT_OFFSET_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   op,
    input  logic [31:0]            request_size,
    input  logic [31:0]            alignment,
    // result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   ok,
    output logic [1:0]             status,
    output logic [31:0]            offset,
    output logic [63:0]            address,
    output logic [31:0]            granted_size
);

    // SW holds any start offset, including the overshoot past the offset
    // range that a wide alignment can cause when OFFSET_WIDTH is small.
    localparam int SW = ((OFFSET_WIDTH > 32) ? OFFSET_WIDTH : 32) + 1;
    localparam int AW = (SW > 64) ? SW : 64;
    localparam logic [SW-1:0] OFS_MASK = {{(SW-OFFSET_WIDTH){1'b0}}, {OFFSET_WIDTH{1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ADD,
        S_CHECK,
        S_FINISH
    } state_t;

    state_t                  state_reg;
    logic [31:0]             capacity_reg;
    logic [63:0]             base_reg;
    logic [OFFSET_WIDTH-1:0] fill_reg;

    // latched request
    logic [31:0]             size_reg;
    logic [31:0]             align_reg;

    // working values
    logic [SW-1:0]           start_reg;
    logic                    res_ok_reg;
    logic                    res_pay_reg;   // result carries a granted region
    logic [1:0]              res_status_reg;
    logic                    fill_we_reg;
    logic [OFFSET_WIDTH-1:0] fill_new_reg;

    // output register
    logic                    out_valid_reg;
    logic                    ok_reg;
    logic [1:0]              status_reg;
    logic [31:0]             offset_reg;
    logic [63:0]             address_reg;
    logic [31:0]             granted_reg;

    rem_ctl_t    rem_ctl;
    rem_sts_t    rem_sts;
    logic [31:0] rem_value;

    logic          in_fire;
    logic          bad_req;
    logic [31:0]   add_amt;
    logic          rem_zero;
    logic [SW-1:0] sum;
    logic [SW-1:0] start_calc;
    logic          align_ovf;
    logic [SW-1:0] cap_sw;
    logic [SW:0]   end_calc;
    logic          no_space;
    logic [AW-1:0] start_ext;
    logic          res_load;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign bad_req  = (capacity_reg == '0) || (request_size == '0) || (alignment == '0);

    assign rem_ctl.start = in_fire && (op == OP_ALLOC) && !bad_req;

    alba_rem_unit #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rem_ctl),
        .dividend  (fill_reg),
        .divisor   (align_reg),
        .sts       (rem_sts),
        .remainder (rem_value)
    );

    always_comb
    begin
        // rounding step: start = fill rounded up to the alignment
        add_amt    = align_reg - rem_value;
        rem_zero   = (rem_value == '0);
        sum        = SW'(fill_reg) + SW'(add_amt);
        start_calc = rem_zero ? SW'(fill_reg) : sum;
        // an increment wider than the offset range skips the overflow code
        // and falls through to the capacity check
        align_ovf  = !rem_zero && (SW'(add_amt) <= OFS_MASK) && (sum > OFS_MASK);

        // fit step: region end against clamped capacity
        cap_sw     = (SW'(capacity_reg) > OFS_MASK) ? OFS_MASK : SW'(capacity_reg);
        end_calc   = {1'b0, start_reg} + (SW+1)'(size_reg);
        no_space   = end_calc > {1'b0, cap_sw};

        start_ext  = AW'(start_reg);
        res_load   = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    end

    // align_reg is latched on accept so the divider sees it from its first step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            capacity_reg   <= '0;
            base_reg       <= '0;
            fill_reg       <= '0;
            size_reg       <= '0;
            align_reg      <= '0;
            start_reg      <= '0;
            res_ok_reg     <= 1'b0;
            res_pay_reg    <= 1'b0;
            res_status_reg <= ST_OK;
            fill_we_reg    <= 1'b0;
            fill_new_reg   <= '0;
            out_valid_reg  <= 1'b0;
            ok_reg         <= 1'b0;
            status_reg     <= ST_OK;
            offset_reg     <= '0;
            address_reg    <= '0;
            granted_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !res_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        size_reg  <= request_size;
                        align_reg <= alignment;
                        start_reg <= '0;
                        if (op == OP_RESET)
                        begin
                            // succeeds with an empty payload
                            res_ok_reg     <= 1'b1;
                            res_pay_reg    <= 1'b0;
                            res_status_reg <= ST_OK;
                            fill_we_reg    <= 1'b1;
                            fill_new_reg   <= '0;
                            state_reg      <= S_FINISH;
                        end
                        else if (bad_req)
                        begin
                            res_ok_reg     <= 1'b0;
                            res_pay_reg    <= 1'b0;
                            res_status_reg <= ST_BAD;
                            fill_we_reg    <= 1'b0;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end

                S_DIV:
                begin
                    if (rem_sts.done)
                    begin
                        state_reg <= S_ADD;
                    end
                end

                S_ADD:
                begin
                    start_reg <= start_calc;
                    if (align_ovf)
                    begin
                        res_ok_reg     <= 1'b0;
                        res_pay_reg    <= 1'b0;
                        res_status_reg <= ST_ALIGN_OVF;
                        fill_we_reg    <= 1'b0;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    if (no_space)
                    begin
                        res_ok_reg     <= 1'b0;
                        res_pay_reg    <= 1'b0;
                        res_status_reg <= ST_NO_SPACE;
                        fill_we_reg    <= 1'b0;
                    end
                    else
                    begin
                        // end fits the clamped capacity, so it fits the range
                        res_ok_reg     <= 1'b1;
                        res_pay_reg    <= 1'b1;
                        res_status_reg <= ST_OK;
                        fill_we_reg    <= 1'b1;
                        fill_new_reg   <= end_calc[OFFSET_WIDTH-1:0];
                    end
                    state_reg <= S_FINISH;
                end

                S_FINISH:
                begin
                    if (res_load)
                    begin
                        out_valid_reg <= 1'b1;
                        ok_reg        <= res_ok_reg;
                        status_reg    <= res_status_reg;
                        offset_reg    <= res_pay_reg ? start_reg[31:0] : '0;
                        address_reg   <= res_pay_reg ? (base_reg + start_ext[63:0]) : '0;
                        granted_reg   <= res_pay_reg ? size_reg : '0;
                        if (fill_we_reg)
                        begin
                            fill_reg <= fill_new_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // configuration must arrive only while idle (the block does not enforce it); capacity re-initializes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CAPACITY:
                    begin
                        capacity_reg <= cfg_data[31:0];
                        fill_reg     <= '0;
                    end
                    CFG_BASE:
                    begin
                        base_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign status       = status_reg;
    assign offset       = offset_reg;
    assign address      = address_reg;
    assign granted_size = granted_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // the remainder unit never runs while a new request can be taken
    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !rem_sts.busy)
        else $error("remainder unit busy while idle");

    // a remainder result only lands while the sequencer waits for it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_sts.done |-> (state_reg == S_DIV))
        else $error("remainder done outside divide state");

    // ok and status agree on every result
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ok == (status == ST_OK)))
        else $error("ok and status disagree");

    // failed results carry zero payload
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (offset == '0 && address == '0 && granted_size == '0))
        else $error("failed result with nonzero payload");

    // a granted region ends within the clamped capacity
    a_fill_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_ok_reg && fill_we_reg) |=> (SW'(fill_reg) <= cap_sw))
        else $error("fill level beyond capacity");

endmodule
